/* sv/hsl2rgb_pkg.sv */
// Shared constants for the HSL to RGB pixel converter.
package hsl2rgb_pkg;

    // Width of each hue, saturation and lightness field
    localparam int IN_W = 17;
    // Width of each color channel
    localparam int CH_W = 8;
    // Packed stream widths (input padded to whole bytes)
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;
    // Register stages from input to output register
    localparam int PIPE_DEPTH = 6;

endpackage

/* sv/hsl_to_rgb_converter_core.sv */
// Usage: converts one pixel per clock from HSL (unsigned, FRAC_BITS fraction bits,
// 17-bit fields) to 8-bit RGB rounded half up and saturated. Items pass from input
// acceptance to the output register through the six-stage pipeline (one
// multiplier stage for the q term, one for the per-channel blend); throughput is one
// item per cycle whenever the output side is ready, and a stall freezes the whole
// pipeline without losing items. The block keeps no state between items.
module hsl_to_rgb_converter_core
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // hue, saturation, lightness, zero pad
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // red, green, blue
);

    localparam int MW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1;
    localparam int PW = IN_W + MW;
    localparam int RW = PW - FRAC_BITS + 1;
    localparam int QW = RW + 3;
    localparam int HW = IN_W + 2;
    localparam int TW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 4;

    localparam logic [MW-1:0]        ONE_M  = MW'(1) << FRAC_BITS;
    localparam logic [MW-1:0]        HALF_M = MW'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0]          HALF_P = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;

    logic                   adv;
    logic [PIPE_DEPTH-1:0]  vld_reg;
    logic [PIPE_DEPTH-1:0]  vld_next;

    logic [IN_W-1:0]        hue_in;
    logic [IN_W-1:0]        sat_in;
    logic [IN_W-1:0]        lit_in;
    logic                   lt_next;
    logic [MW-1:0]          mul_b;
    logic [PW-1:0]          prod_next;
    logic [HW-1:0]          h3_next;

    logic                   lt_reg;
    logic [PW-1:0]          prod_reg;
    logic [IN_W-1:0]        lit_reg;
    logic [IN_W-1:0]        sat_reg;
    logic [HW-1:0]          h3_reg;

    logic [PW:0]            rsum_w;
    logic signed [QW-1:0]   rnd_q;
    logic signed [QW-1:0]   lit_q;
    logic signed [QW-1:0]   sat_q;
    logic signed [QW-1:0]   q_next;
    logic signed [QW-1:0]   p_next;
    logic signed [TW-1:0]   h3_t;
    logic signed [QW-1:0]   q_reg;
    logic signed [QW-1:0]   p_reg;
    logic signed [TW-1:0]   t3_reg [3];

    logic [CH_W-1:0]        red;
    logic [CH_W-1:0]        green;
    logic [CH_W-1:0]        blue;

    // Whole pipeline moves when the output register is free or being drained
    assign adv           = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: l*s or l*(1+s), and 3*h
    assign hue_in = s_axis_tdata[IN_W-1:0];
    assign sat_in = s_axis_tdata[2*IN_W-1:IN_W];
    assign lit_in = s_axis_tdata[3*IN_W-1:2*IN_W];

    assign lt_next   = MW'(lit_in) < HALF_M;
    assign mul_b     = lt_next ? (ONE_M + MW'(sat_in)) : MW'(sat_in);
    assign prod_next = PW'(lit_in) * PW'(mul_b);
    assign h3_next   = (HW'(hue_in) << 1) + HW'(hue_in);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lt_reg   <= lt_next;
            prod_reg <= prod_next;
            lit_reg  <= lit_in;
            sat_reg  <= sat_in;
            h3_reg   <= h3_next;
        end
    end

    // Stage 2: round the product, form q and p, offset hue per channel
    assign rsum_w = {1'b0, prod_reg} + HALF_P;
    assign rnd_q  = $signed(QW'(rsum_w[PW:FRAC_BITS]));
    assign lit_q  = $signed(QW'(lit_reg));
    assign sat_q  = $signed(QW'(sat_reg));
    assign q_next = lt_reg ? rnd_q : (lit_q + sat_q - rnd_q);
    assign p_next = (lit_q <<< 1) - q_next;
    assign h3_t   = $signed(TW'(h3_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg     <= q_next;
            p_reg     <= p_next;
            t3_reg[0] <= h3_t + ONE_T;
            t3_reg[1] <= h3_t;
            t3_reg[2] <= h3_t - ONE_T;
        end
    end

    // Stages 3 to 6: one channel unit per color
    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_red (
        .clk  (clk),
        .en   (adv),
        .p    (p_reg),
        .q    (q_reg),
        .t3   (t3_reg[0]),
        .chan (red)
    );

    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_green (
        .clk  (clk),
        .en   (adv),
        .p    (p_reg),
        .q    (q_reg),
        .t3   (t3_reg[1]),
        .chan (green)
    );

    hsl2rgb_channel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blue (
        .clk  (clk),
        .en   (adv),
        .p    (p_reg),
        .q    (q_reg),
        .t3   (t3_reg[2]),
        .chan (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

/* sv/hsl2rgb_channel.sv */
// One color channel: hue curve segment select, blend multiply, scale to a byte.
module hsl2rgb_channel
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [((((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1 + IN_W)
                          - FRAC_BITS + 4) - 1:0] p,
    input  logic signed [((((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1 + IN_W)
                          - FRAC_BITS + 4) - 1:0] q,
    input  logic signed [(((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 4) - 1:0] t3,
    output logic [CH_W-1:0]     chan
);

    localparam int MW   = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 1;
    localparam int PW   = IN_W + MW;
    localparam int RW   = PW - FRAC_BITS + 1;
    localparam int QW   = RW + 3;
    localparam int DW   = QW + 1;
    localparam int TW   = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 4;
    localparam int KW   = FRAC_BITS + 1;
    localparam int MULW = DW + KW + 1;
    localparam int CW   = DW + FRAC_BITS + 3;
    localparam int VW   = CW + 9;

    localparam logic signed [TW-1:0] ONE_T   = TW'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] TWO_T   = ONE_T <<< 1;
    localparam logic signed [TW-1:0] THREE_T = ONE_T + (ONE_T <<< 1);
    localparam logic signed [TW-1:0] FOUR_T  = ONE_T <<< 2;
    localparam logic [KW-1:0]        ONE_K   = KW'(1) << FRAC_BITS;
    localparam logic signed [VW-1:0] ROUND_V = VW'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [VW-1:0] MAX_V   = VW'(255);

    logic signed [TW-1:0]   t3_wrap;
    logic signed [TW-1:0]   t3_dbl;
    logic signed [TW-1:0]   fall_w;
    logic [KW-1:0]          k_next;
    logic [KW-1:0]          k_reg;
    logic signed [DW-1:0]   d_next;
    logic signed [DW-1:0]   d_reg;
    logic signed [QW-1:0]   p_c1_reg;
    logic signed [MULW-1:0] dk_next;
    logic signed [MULW-1:0] dk_reg;
    logic signed [QW-1:0]   p_c2_reg;
    logic signed [CW-1:0]   c_next;
    logic signed [CW-1:0]   c_reg;
    logic signed [VW-1:0]   scaled_w;
    logic signed [VW-1:0]   v_w;
    logic [CH_W-1:0]        chan_next;
    logic [CH_W-1:0]        chan_reg;

    // Single wrap of 3*t into 0..3
    always_comb
    begin
        t3_wrap = t3;
        if (t3 < 0)
        begin
            t3_wrap = t3 + THREE_T;
        end
        else if (t3 > THREE_T)
        begin
            t3_wrap = t3 - THREE_T;
        end
    end

    // Segment select: blend weight applied to q-p
    assign t3_dbl = t3_wrap <<< 1;
    assign fall_w = FOUR_T - t3_dbl;

    always_comb
    begin
        priority if (t3_dbl < ONE_T)
        begin
            k_next = t3_dbl[KW-1:0];
        end
        else if (t3_dbl < THREE_T)
        begin
            k_next = ONE_K;
        end
        else if (t3_wrap < TWO_T)
        begin
            k_next = fall_w[KW-1:0];
        end
        else
        begin
            k_next = '0;
        end
    end

    assign d_next = DW'(q) - DW'(p);

    // Blend product and base term
    assign dk_next = d_reg * signed'({1'b0, k_reg});
    assign c_next  = (CW'(p_c2_reg) <<< FRAC_BITS) + CW'(dk_reg);

    // Times 255, round half up, clamp to a byte
    assign scaled_w = (VW'(c_reg) <<< 8) - VW'(c_reg) + ROUND_V;
    assign v_w      = scaled_w >>> (2 * FRAC_BITS);

    always_comb
    begin
        if (v_w < 0)
        begin
            chan_next = '0;
        end
        else if (v_w > MAX_V)
        begin
            chan_next = '1;
        end
        else
        begin
            chan_next = v_w[CH_W-1:0];
        end
    end

    // Payload stages advance together with the top level valid chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg    <= k_next;
            d_reg    <= d_next;
            p_c1_reg <= p;
            dk_reg   <= dk_next;
            p_c2_reg <= p_c1_reg;
            c_reg    <= c_next;
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule
